### src/rrd_pkg.sv
package rrd_pkg;

	localparam int unsigned LEN_W = 31;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OFS_W = 5;

	localparam logic [OFS_W-1:0] CALL_HDR_BYTES = 5'd24;
	localparam logic [WORD_W-1:0] RPC_VERSION = 32'd2;
	localparam logic [WORD_W-1:0] MSG_TYPE_CALL = 32'd0;
	localparam logic [WORD_W-1:0] MAX_KNOWN_PROC = 32'd1;

	localparam logic [LEN_W-1:0] MAX_FRAG_RESET = 31'd52428800;
	localparam logic [WORD_W-1:0] PROGRAM_RESET = 32'd100003;
	localparam logic [WORD_W-1:0] VERSION_RESET = 32'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd2;

	localparam logic [2:0] HW_XID = 3'd0;
	localparam logic [2:0] HW_MSG_TYPE = 3'd1;
	localparam logic [2:0] HW_RPC_VERS = 3'd2;
	localparam logic [2:0] HW_PROGRAM = 3'd3;
	localparam logic [2:0] HW_VERSION = 3'd4;
	localparam logic [2:0] HW_PROC = 3'd5;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOT_CALL = 3'd1;
	localparam logic [2:0] ST_RPC_VERS = 3'd2;
	localparam logic [2:0] ST_PROGRAM = 3'd3;
	localparam logic [2:0] ST_VERSION = 3'd4;
	localparam logic [2:0] ST_PROC = 3'd5;
	localparam logic [2:0] ST_SHORT = 3'd6;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_DATA   = 3'b010,
		PH_ERROR  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [LEN_W-1:0]  max_fragment_length;
		logic [WORD_W-1:0] program_number;
		logic [WORD_W-1:0] program_version;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [7:0]        data_byte;
		logic              end_of_message;
		logic [WORD_W-1:0] transaction_id;
		logic [WORD_W-1:0] procedure_number;
		logic [2:0]        header_status;
	} result_t;

endpackage

### src/rrd_channels.sv
interface rrd_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface rrd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  data_byte;
	logic        end_of_message;
	logic [31:0] transaction_id;
	logic [31:0] procedure_number;
	logic [2:0]  header_status;

	modport source (
		output valid, output result_kind, output data_byte, output end_of_message,
		output transaction_id, output procedure_number, output header_status,
		input ready
	);
	modport sink (
		input valid, input result_kind, input data_byte, input end_of_message,
		input transaction_id, input procedure_number, input header_status,
		output ready
	);
endinterface

### src/rrd_front.sv
module rrd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  rrd_pkg::cfg_t       cfg,
	rrd_stream_if.sink          in_ch,
	input  logic                q_full,
	output logic                push,
	output rrd_pkg::result_t    push_data
);

	rrd_pkg::phase_t                phase_q, n_phase;
	logic [1:0]                     hdr_cnt_q, n_hdr_cnt;
	logic [23:0]                    hdr_shift_q, n_hdr_shift;
	logic [rrd_pkg::LEN_W-1:0]      remain_q, n_remain;
	logic                           last_q, n_last;
	logic [rrd_pkg::OFS_W-1:0]      offset_q, n_offset;
	logic [23:0]                    word_q, n_word;
	logic [rrd_pkg::WORD_W-1:0]     xid_q, n_xid;
	logic [rrd_pkg::WORD_W-1:0]     proc_q, n_proc;
	logic [2:0]                     status_q, n_status;
	logic [31:0]                    hs;
	logic [31:0]                    ws;
	logic                           last_new;
	logic                           eom;
	logic                           fail;
	logic [2:0]                     fail_code;
	logic                           accept;

	assign in_ch.ready = !q_full;
	assign accept = in_ch.valid && !q_full;

	always_comb begin
		n_phase = phase_q;
		n_hdr_cnt = hdr_cnt_q;
		n_hdr_shift = hdr_shift_q;
		n_remain = remain_q;
		n_last = last_q;
		n_offset = offset_q;
		n_word = word_q;
		n_xid = xid_q;
		n_proc = proc_q;
		n_status = status_q;
		hs = {hdr_shift_q, in_ch.stream_byte};
		ws = {word_q, in_ch.stream_byte};
		last_new = last_q | hs[31];
		eom = 1'b0;
		fail = 1'b0;
		fail_code = rrd_pkg::ST_OK;
		push = 1'b0;
		push_data = '0;
		unique case (phase_q)
			rrd_pkg::PH_HEADER: begin
				n_hdr_shift = hs[23:0];
				if (hdr_cnt_q != 2'd3) begin
					n_hdr_cnt = hdr_cnt_q + 2'd1;
				end else begin
					n_hdr_cnt = 2'd0;
					n_last = last_new;
					if (hs[30:0] > cfg.max_fragment_length) begin
						n_phase = rrd_pkg::PH_ERROR;
						push = 1'b1;
						push_data.result_kind = rrd_pkg::KIND_ERROR;
					end else if (hs[30:0] == '0) begin
						if (last_new) begin
							push = 1'b1;
							push_data.result_kind = rrd_pkg::KIND_EMPTY;
							push_data.end_of_message = 1'b1;
							push_data.transaction_id = xid_q;
							push_data.procedure_number = proc_q;
							push_data.header_status = (offset_q < rrd_pkg::CALL_HDR_BYTES) ?
								rrd_pkg::ST_SHORT : status_q;
							n_last = 1'b0;
							n_offset = '0;
							n_word = '0;
							n_xid = '0;
							n_proc = '0;
							n_status = rrd_pkg::ST_OK;
						end
					end else begin
						n_remain = hs[30:0];
						n_phase = rrd_pkg::PH_DATA;
					end
				end
			end
			rrd_pkg::PH_DATA: begin
				if (offset_q < rrd_pkg::CALL_HDR_BYTES) begin
					n_word = ws[23:0];
					if (offset_q[1:0] == 2'd3) begin
						unique case (offset_q[4:2])
							rrd_pkg::HW_XID: n_xid = ws;
							rrd_pkg::HW_MSG_TYPE: begin
								fail = (ws != rrd_pkg::MSG_TYPE_CALL);
								fail_code = rrd_pkg::ST_NOT_CALL;
							end
							rrd_pkg::HW_RPC_VERS: begin
								fail = (ws != rrd_pkg::RPC_VERSION);
								fail_code = rrd_pkg::ST_RPC_VERS;
							end
							rrd_pkg::HW_PROGRAM: begin
								fail = (ws != cfg.program_number);
								fail_code = rrd_pkg::ST_PROGRAM;
							end
							rrd_pkg::HW_VERSION: begin
								fail = (ws != cfg.program_version);
								fail_code = rrd_pkg::ST_VERSION;
							end
							rrd_pkg::HW_PROC: begin
								n_proc = ws;
								fail = (ws > rrd_pkg::MAX_KNOWN_PROC);
								fail_code = rrd_pkg::ST_PROC;
							end
							default: ;
						endcase
					end
					if (fail && status_q == rrd_pkg::ST_OK) begin
						n_status = fail_code;
					end
					n_offset = offset_q + 5'd1;
				end
				n_remain = remain_q - 31'd1;
				if (n_remain == '0) begin
					n_phase = rrd_pkg::PH_HEADER;
					eom = last_q;
				end
				push = 1'b1;
				push_data.result_kind = rrd_pkg::KIND_DATA;
				push_data.data_byte = in_ch.stream_byte;
				push_data.end_of_message = eom;
				if (eom) begin
					push_data.transaction_id = n_xid;
					push_data.procedure_number = n_proc;
					push_data.header_status = (n_offset < rrd_pkg::CALL_HDR_BYTES) ?
						rrd_pkg::ST_SHORT : n_status;
					n_last = 1'b0;
					n_offset = '0;
					n_word = '0;
					n_xid = '0;
					n_proc = '0;
					n_status = rrd_pkg::ST_OK;
				end
			end
			rrd_pkg::PH_ERROR: ;
			default: ;
		endcase
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rrd_pkg::PH_HEADER;
			hdr_cnt_q <= '0;
			hdr_shift_q <= '0;
			remain_q <= '0;
			last_q <= 1'b0;
			offset_q <= '0;
			word_q <= '0;
			xid_q <= '0;
			proc_q <= '0;
			status_q <= rrd_pkg::ST_OK;
		end else if (accept) begin
			phase_q <= n_phase;
			hdr_cnt_q <= n_hdr_cnt;
			hdr_shift_q <= n_hdr_shift;
			remain_q <= n_remain;
			last_q <= n_last;
			offset_q <= n_offset;
			word_q <= n_word;
			xid_q <= n_xid;
			proc_q <= n_proc;
			status_q <= n_status;
		end
	end

endmodule

### src/rrd_queue.sv
module rrd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rrd_pkg::result_t push_data,
	output logic             full,
	rrd_result_if.source     out_ch
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rrd_pkg::result_t  entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;
	rrd_pkg::result_t  head;

	assign full = (count_q == CNT_W'(DEPTH));
	assign out_ch.valid = (count_q != '0);
	assign pop = out_ch.valid && out_ch.ready;
	assign head = entry_q[rd_ptr_q];

	assign out_ch.result_kind = head.result_kind;
	assign out_ch.data_byte = head.data_byte;
	assign out_ch.end_of_message = head.end_of_message;
	assign out_ch.transaction_id = head.transaction_id;
	assign out_ch.procedure_number = head.procedure_number;
	assign out_ch.header_status = head.header_status;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/rpc_record_deframer_call_check_top.sv
// channel   dir  payload                                   handshake
// in_ch     in   stream_byte                               valid/ready
// out_ch    out  result_kind, data_byte, end_of_message,   valid/ready
//                transaction_id, procedure_number, header_status
// cfg       in   cfg_index, cfg_data                       cfg_we
//
// One byte per cycle while not full; a result is queued the cycle its byte is taken.
// The front parser updates counters and compares combinationally for each byte taken.
// A DEPTH-entry queue separates parser and output; in_ch.ready drops only when it is full.
// Reset clears parser state, queue pointers and loads register defaults at once.
module rpc_record_deframer_call_check_top #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrd_pkg::WORD_W-1:0]     cfg_data,
	rrd_stream_if.sink                     in_ch,
	rrd_result_if.source                   out_ch
);

	rrd_pkg::cfg_t    cfg_q;
	logic             q_full;
	logic             push;
	rrd_pkg::result_t push_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_fragment_length <= rrd_pkg::MAX_FRAG_RESET;
			cfg_q.program_number <= rrd_pkg::PROGRAM_RESET;
			cfg_q.program_version <= rrd_pkg::VERSION_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rrd_pkg::CFG_MAX_FRAG: cfg_q.max_fragment_length <= cfg_data[rrd_pkg::LEN_W-1:0];
				rrd_pkg::CFG_PROGRAM: cfg_q.program_number <= cfg_data;
				rrd_pkg::CFG_VERSION: cfg_q.program_version <= cfg_data;
				default: ;
			endcase
		end
	end

	rrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	rrd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.out_ch    (out_ch)
	);

endmodule

### src/rrd_checker.sv
module rrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic [7:0]  out_data,
	input logic        out_eom,
	input logic [31:0] out_xid,
	input logic [31:0] out_proc,
	input logic [2:0]  out_status
);

	// hold a stalled request
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data)
			&& $stable(out_eom) && $stable(out_xid) && $stable(out_proc)
			&& $stable(out_status))
		else $error("stalled output request changed");

	// an oversized fragment is the last result ever
	a_error_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_kind == rrd_pkg::KIND_ERROR |=> !out_valid)
		else $error("result after fragment error");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output queue empty");

endmodule

bind rpc_record_deframer_call_check_top rrd_checker u_rrd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_kind   (out_ch.result_kind),
	.out_data   (out_ch.data_byte),
	.out_eom    (out_ch.end_of_message),
	.out_xid    (out_ch.transaction_id),
	.out_proc   (out_ch.procedure_number),
	.out_status (out_ch.header_status)
);

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned LIMIT = 300000;
	localparam int unsigned DRAIN = 16;
	localparam int unsigned HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rrd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rrd_pkg::WORD_W-1:0] cfg_data;

	rrd_stream_if in_if();
	rrd_result_if out_if();

	rpc_record_deframer_call_check_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	logic [rrd_pkg::LEN_W-1:0] max_len;
	logic [rrd_pkg::WORD_W-1:0] prog_req;
	logic [rrd_pkg::WORD_W-1:0] vers_req;

	rrd_pkg::phase_t frame_phase;
	logic [1:0] hdr_cnt;
	logic [rrd_pkg::WORD_W-1:0] hdr_word;
	logic [rrd_pkg::LEN_W-1:0] frag_left;
	logic last_flag;
	logic [rrd_pkg::OFS_W-1:0] msg_ofs;
	logic [rrd_pkg::WORD_W-1:0] call_word;
	logic [rrd_pkg::WORD_W-1:0] cap_xid;
	logic [rrd_pkg::WORD_W-1:0] cap_proc;
	logic [2:0] cap_status;

	logic [7:0] tx_bytes [$];
	rrd_pkg::result_t expected_results [$];
	rrd_pkg::result_t oldest;

	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit req_taken = 0;
	bit idle_on = 1;
	bit hold_armed = 0;
	bit hold_done = 0;
	int unsigned hold_left = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic clear_message_state();
		last_flag = 1'b0;
		msg_ofs = '0;
		call_word = '0;
		cap_xid = '0;
		cap_proc = '0;
		cap_status = rrd_pkg::ST_OK;
	endtask

	task automatic note_fault(input logic [2:0] code);
		if (cap_status == rrd_pkg::ST_OK)
			cap_status = code;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		rrd_pkg::result_t r;
		logic [rrd_pkg::LEN_W-1:0] len;
		logic produced;
		r = '0;
		produced = 1'b0;
		case (frame_phase)
		rrd_pkg::PH_HEADER: begin
			hdr_word = {hdr_word[23:0], b};
			if (hdr_cnt != 2'd3) begin
				hdr_cnt = hdr_cnt + 2'd1;
			end else begin
				hdr_cnt = '0;
				if (hdr_word[31])
					last_flag = 1'b1;
				len = hdr_word[rrd_pkg::LEN_W-1:0];
				if (len > max_len) begin
					frame_phase = rrd_pkg::PH_ERROR;
					r.result_kind = rrd_pkg::KIND_ERROR;
					produced = 1'b1;
				end else if (len == '0) begin
					if (last_flag) begin
						r.result_kind = rrd_pkg::KIND_EMPTY;
						r.end_of_message = 1'b1;
						produced = 1'b1;
					end
				end else begin
					frag_left = len;
					frame_phase = rrd_pkg::PH_DATA;
				end
			end
		end
		rrd_pkg::PH_DATA: begin
			if (msg_ofs < rrd_pkg::CALL_HDR_BYTES) begin
				call_word = {call_word[23:0], b};
				if (msg_ofs[1:0] == 2'd3) begin
					case (msg_ofs[4:2])
					rrd_pkg::HW_XID: cap_xid = call_word;
					rrd_pkg::HW_MSG_TYPE:
						if (call_word != rrd_pkg::MSG_TYPE_CALL)
							note_fault(rrd_pkg::ST_NOT_CALL);
					rrd_pkg::HW_RPC_VERS:
						if (call_word != rrd_pkg::RPC_VERSION)
							note_fault(rrd_pkg::ST_RPC_VERS);
					rrd_pkg::HW_PROGRAM:
						if (call_word != prog_req)
							note_fault(rrd_pkg::ST_PROGRAM);
					rrd_pkg::HW_VERSION:
						if (call_word != vers_req)
							note_fault(rrd_pkg::ST_VERSION);
					rrd_pkg::HW_PROC: begin
						cap_proc = call_word;
						if (call_word > rrd_pkg::MAX_KNOWN_PROC)
							note_fault(rrd_pkg::ST_PROC);
					end
					default: ;
					endcase
				end
				msg_ofs = msg_ofs + 1'b1;
			end
			frag_left = frag_left - 1'b1;
			r.result_kind = rrd_pkg::KIND_DATA;
			r.data_byte = b;
			produced = 1'b1;
			if (frag_left == '0) begin
				frame_phase = rrd_pkg::PH_HEADER;
				r.end_of_message = last_flag;
			end
		end
		default: ;
		endcase
		if (r.end_of_message) begin
			r.transaction_id = cap_xid;
			r.procedure_number = cap_proc;
			r.header_status = (msg_ofs < rrd_pkg::CALL_HDR_BYTES) ?
				rrd_pkg::ST_SHORT : cap_status;
			clear_message_state();
		end
		if (produced)
			expected_results.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic queue_header(input logic last, input logic [rrd_pkg::LEN_W-1:0] len);
		logic [31:0] w;
		w = {last, len};
		for (int k = 3; k >= 0; k--)
			tx_bytes.push_back(w[8*k +: 8]);
	endtask

	task automatic queue_call(input int unsigned cap);
		logic [31:0] word [6];
		logic [4:0] bad;
		logic [7:0] body [$];
		int unsigned flaw;
		int unsigned chunk;
		int unsigned left;
		int unsigned keep;
		logic end_empty;
		flaw = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 7);
		case (flaw)
		0, 6: bad = '0;
		7: bad = 5'($urandom_range(1, 31));
		default: bad = 5'd1 << (flaw - 1);
		endcase
		word[0] = $urandom;
		word[1] = rrd_pkg::MSG_TYPE_CALL ^ (bad[0] ? ($urandom | 32'h1) : 32'h0);
		word[2] = rrd_pkg::RPC_VERSION ^ (bad[1] ? (32'h1 << $urandom_range(0, 31)) : 32'h0);
		word[3] = prog_req ^ (bad[2] ? (32'h1 << $urandom_range(0, 31)) : 32'h0);
		word[4] = vers_req ^ (bad[3] ? (32'h1 << $urandom_range(0, 31)) : 32'h0);
		if (bad[4])
			word[5] = $urandom_range(0, 1) ? 32'd2 : ($urandom | 32'h2);
		else
			word[5] = $urandom_range(0, 1);
		for (int i = 0; i < 6; i++)
			for (int k = 3; k >= 0; k--)
				body.push_back(word[i][8*k +: 8]);
		repeat ($urandom_range(0, 20))
			body.push_back(8'($urandom));
		if (flaw == 6) begin
			keep = $urandom_range(0, 23);
			while (body.size() > keep)
				void'(body.pop_back());
		end
		if (cap == 0)
			body.delete();
		left = body.size();
		end_empty = (left == 0) || ($urandom_range(0, 5) == 0);
		while (left != 0) begin
			chunk = $urandom_range(1, (cap < 16) ? cap : 16);
			if ($urandom_range(0, 5) == 0)
				chunk = (cap < left) ? cap : left;
			if (chunk > left)
				chunk = left;
			if ($urandom_range(0, 9) == 0)
				queue_header(1'b0, '0);
			queue_header(chunk == left && !end_empty, chunk[rrd_pkg::LEN_W-1:0]);
			repeat (chunk)
				tx_bytes.push_back(body.pop_front());
			left -= chunk;
		end
		if (end_empty)
			queue_header(1'b1, '0);
	endtask

	task automatic write_reg(input logic [rrd_pkg::CFG_IDX_W-1:0] idx,
		input logic [rrd_pkg::WORD_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
		rrd_pkg::CFG_MAX_FRAG: max_len = value[rrd_pkg::LEN_W-1:0];
		rrd_pkg::CFG_PROGRAM: prog_req = value;
		rrd_pkg::CFG_VERSION: vers_req = value;
		default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (tx_bytes.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		req_taken = 1'b0;
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				deframe_byte(in_if.stream_byte);
				void'(tx_bytes.pop_front());
				req_taken = 1'b1;
			end
			if (out_if.valid && out_if.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual kind %0h data %0h",
						$time, out_if.result_kind, out_if.data_byte);
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("result_kind", 32'(oldest.result_kind),
						32'(out_if.result_kind));
					check_field("data_byte", 32'(oldest.data_byte), 32'(out_if.data_byte));
					check_field("end_of_message", 32'(oldest.end_of_message),
						32'(out_if.end_of_message));
					check_field("transaction_id", oldest.transaction_id,
						out_if.transaction_id);
					check_field("procedure_number", oldest.procedure_number,
						out_if.procedure_number);
					check_field("header_status", 32'(oldest.header_status),
						32'(out_if.header_status));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!in_if.valid || req_taken) begin
			if (tx_gap != 0) begin
				tx_gap--;
				in_if.valid <= 1'b0;
			end else if (tx_bytes.size() == 0) begin
				in_if.valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				tx_gap = $urandom_range(0, 17);
				in_if.valid <= 1'b0;
			end else begin
				in_if.valid <= 1'b1;
				in_if.stream_byte <= tx_bytes[0];
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_if.ready <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_if.ready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap--;
			out_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			rx_gap = $urandom_range(0, 17);
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		in_if.valid = 1'b0;
		in_if.stream_byte = '0;
		out_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		max_len = rrd_pkg::MAX_FRAG_RESET;
		prog_req = rrd_pkg::PROGRAM_RESET;
		vers_req = rrd_pkg::VERSION_RESET;
		frame_phase = rrd_pkg::PH_HEADER;
		hdr_cnt = '0;
		hdr_word = '0;
		frag_left = '0;
		clear_message_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty and short messages, byte extremes
		queue_header(1'b0, '0);
		queue_header(1'b1, '0);
		queue_header(1'b1, 31'd1);
		tx_bytes.push_back(8'hFF);
		queue_header(1'b0, 31'd2);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		queue_header(1'b1, '0);

		while (tx_bytes.size() < 480)
			queue_call(32'(max_len));
		hold_armed = 1'b1;
		wait_idle();

		write_reg(rrd_pkg::CFG_MAX_FRAG, 32'hFFFF_FFFF);
		write_reg(rrd_pkg::CFG_PROGRAM, 32'h0);
		write_reg(rrd_pkg::CFG_VERSION, 32'hFFFF_FFFF);
		@(posedge clk);
		while (tx_bytes.size() < 400)
			queue_call(32'(max_len));
		wait_idle();

		write_reg(rrd_pkg::CFG_MAX_FRAG, 32'h0);
		@(posedge clk);
		repeat (8) queue_call(32'(max_len));
		wait_idle();

		write_reg(rrd_pkg::CFG_MAX_FRAG, 32'd24);
		write_reg(rrd_pkg::CFG_PROGRAM, 32'hFFFF_FFFF);
		write_reg(rrd_pkg::CFG_VERSION, 32'h0);
		@(posedge clk);
		while (tx_bytes.size() < 200)
			queue_call(32'(max_len));
		while (tx_bytes.size() != 0)
			@(posedge clk);
		idle_on = 1'b0;
		while (tx_bytes.size() < 200)
			queue_call(32'(max_len));
		wait_idle();

		// oversized fragment, then drop everything
		queue_header(1'($urandom_range(0, 1)),
			$urandom_range(0, 1) ? max_len + 1'b1 : {rrd_pkg::LEN_W{1'b1}});
		repeat (8) tx_bytes.push_back(8'($urandom));
		wait_idle();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
src/rrd_pkg.sv
src/rrd_channels.sv
src/rrd_front.sv
src/rrd_queue.sv
src/rpc_record_deframer_call_check_top.sv
src/rrd_checker.sv
test/testbench.sv
